[rtl/spwc_pkg.sv]
// Shared types and constants for the servo pulse width commander.
`timescale 1ns / 1ps

package spwc_pkg;

   // Request kinds
   localparam logic [1:0] KIND_ROTATE   = 2'd0;
   localparam logic [1:0] KIND_TIMED    = 2'd1;
   localparam logic [1:0] KIND_POSITION = 2'd2;
   localparam logic [1:0] KIND_TICK     = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_REVERSE = 2'd0;
   localparam logic [1:0] CSR_MIN     = 2'd1;
   localparam logic [1:0] CSR_MAX     = 2'd2;

   localparam logic [11:0] MIN_PULSE_RESET = 12'd1000;
   localparam logic [11:0] MAX_PULSE_RESET = 12'd2000;

   localparam int AMOUNT_W = 8;
   localparam int DUR_W    = 24;
   localparam int REM_W    = DUR_W + 1;
   localparam int PULSE_W  = 13;
   localparam int CFG_W    = 12;
   localparam int N_W      = AMOUNT_W + 1;    // offset amount, signed
   localparam int DIFF_W   = CFG_W + 1;       // end - start, signed
   localparam int PROD_W   = N_W + DIFF_W;    // signed product
   localparam int MAG_W    = 20;              // |product| < 2^20
   localparam int RECIP_W  = 21;
   localparam int QUOT_W   = 14;              // |quotient| <= 9295
   localparam int SUM_W    = 15;              // start +/- quotient, signed

   // Reciprocal of 100 scaled by 2^27 (and of 200 by 2^28), rounded up.
   // Exact floor division for every dividend below 2^20.
   localparam logic [RECIP_W-1:0] RECIP_M = 21'd1342178;
   localparam int SHIFT_100 = 27;
   localparam int SHIFT_200 = 28;

   localparam logic signed [N_W-1:0] SPEED_OFFSET = 9'sd100;
   localparam logic [PULSE_W-1:0] PULSE_MAX = 13'd8191;

   // Command handed from the accept stage into the mapping pipeline
   typedef struct packed {
      logic signed [N_W-1:0] n;        // x - lo
      logic                  div200;   // 1: divide by 200, 0: by 100
      logic                  written;
      logic                  active;
   } cmd_type;

   // Flags that ride along the mapping pipeline
   typedef struct packed {
      logic div200;
      logic written;
      logic active;
   } flags_type;

endpackage

[rtl/spwc_map.sv]
// Mapping pipeline: product, reciprocal divide, offset and saturate.
`timescale 1ns / 1ps

module spwc_map (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  spwc_pkg::cmd_type                  in_cmd,
   input  logic signed [spwc_pkg::DIFF_W-1:0] span,
   input  logic        [spwc_pkg::CFG_W-1:0]  start,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic        [spwc_pkg::PULSE_W-1:0] out_pulse,
   output spwc_pkg::flags_type                out_flags
);

   // product stage
   logic                                b_valid_ff;
   logic signed [spwc_pkg::PROD_W-1:0]  b_prod_ff;
   spwc_pkg::flags_type                 b_flags_ff;
   // quotient stage
   logic                                c_valid_ff;
   logic        [spwc_pkg::QUOT_W-1:0]  c_quot_ff, c_quot_in;
   logic                                c_neg_ff;
   spwc_pkg::flags_type                 c_flags_ff;
   // output stage
   logic                                o_valid_ff;
   logic        [spwc_pkg::PULSE_W-1:0] o_pulse_ff, o_pulse_in;
   spwc_pkg::flags_type                 o_flags_ff;

   logic                                o_ready, c_ready, b_ready;
   logic signed [spwc_pkg::PROD_W-1:0]  b_prod_in;
   logic        [spwc_pkg::PROD_W-1:0]  abs_prod;
   logic        [spwc_pkg::MAG_W+spwc_pkg::RECIP_W-1:0] recip_prod;
   logic signed [spwc_pkg::SUM_W-1:0]   sum;

   assign o_ready  = !o_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || o_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign in_ready = b_ready;

   assign b_prod_in = spwc_pkg::PROD_W'(in_cmd.n) * spwc_pkg::PROD_W'(span);

   // truncating divide: divide the magnitude, restore the sign later
   always_comb begin
      abs_prod   = b_prod_ff[spwc_pkg::PROD_W-1] ? spwc_pkg::PROD_W'(-b_prod_ff)
                                                 : spwc_pkg::PROD_W'(b_prod_ff);
      recip_prod = abs_prod[spwc_pkg::MAG_W-1:0] * spwc_pkg::RECIP_M;
      if (b_flags_ff.div200) begin
         c_quot_in = spwc_pkg::QUOT_W'(recip_prod >> spwc_pkg::SHIFT_200);
      end else begin
         c_quot_in = spwc_pkg::QUOT_W'(recip_prod >> spwc_pkg::SHIFT_100);
      end
   end

   always_comb begin
      if (c_neg_ff) begin
         sum = $signed({3'b000, start}) - $signed({1'b0, c_quot_ff});
      end else begin
         sum = $signed({3'b000, start}) + $signed({1'b0, c_quot_ff});
      end
      if (!c_flags_ff.written || sum < 0) begin
         o_pulse_in = '0;
      end else if (sum > $signed({2'b00, spwc_pkg::PULSE_MAX})) begin
         o_pulse_in = spwc_pkg::PULSE_MAX;
      end else begin
         o_pulse_in = sum[spwc_pkg::PULSE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (b_ready) b_valid_ff <= in_valid;
         if (c_ready) c_valid_ff <= b_valid_ff;
         if (o_ready) o_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready) begin
         b_prod_ff  <= b_prod_in;
         b_flags_ff <= '{div200: in_cmd.div200, written: in_cmd.written,
                         active: in_cmd.active};
      end
      if (c_ready) begin
         c_quot_ff  <= c_quot_in;
         c_neg_ff   <= b_prod_ff[spwc_pkg::PROD_W-1];
         c_flags_ff <= b_flags_ff;
      end
      if (o_ready) begin
         o_pulse_ff <= o_pulse_in;
         o_flags_ff <= c_flags_ff;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_pulse = o_pulse_ff;
   assign out_flags = o_flags_ff;

endmodule

[rtl/servo_pulse_width_commander_top.sv]
// Top level of the servo pulse width commander.
//
// Usage:
//   req_*  : request channel. tuser carries the kind (rotate, timed rotate,
//            position, one millisecond tick); tdata carries amount and
//            duration_ms. A request is taken when req_tvalid and req_tready
//            are both high.
//   rsp_*  : one result per request, in order: the commanded pulse width,
//            whether a new width was commanded, and whether a timed run is
//            still counting down.
//   csr_*  : register writes (reverse, minimum width, maximum width); always
//            ready. Write only while no request is in flight.
// One request per cycle is sustained while rsp_tready stays high. The path is
// an accept register, a 9x13 product register, a reciprocal-multiply divide
// register and a saturating output register.
// The countdown is updated as a request is taken.
// Reset (synchronous) restores 1000/2000 us, no reversal, no timed run,
// and empties the pipeline. When rsp_tready is low, results hold and bubbles
// fill in; req_tready drops only once every stage holds a result.
`timescale 1ns / 1ps

module servo_pulse_width_commander_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [7:0] amount (signed), [31:8] duration_ms
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [12:0] pulse_us, [13] timed_run_active, [15:14] zero
   output logic        rsp_tuser,   // [0] pulse_written
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   logic                               reverse_ff;
   logic [spwc_pkg::CFG_W-1:0]         min_ff, max_ff;
   logic [spwc_pkg::REM_W-1:0]         rem_ff, rem_in;
   logic                               a_valid_ff;
   spwc_pkg::cmd_type                  a_cmd_ff, a_cmd_in;
   logic                               a_ready, map_ready, req_fire;
   logic signed [spwc_pkg::AMOUNT_W-1:0] amount;
   logic [spwc_pkg::DUR_W-1:0]         duration;
   logic [1:0]                         kind;
   logic [spwc_pkg::CFG_W-1:0]         start, stop;
   logic signed [spwc_pkg::DIFF_W-1:0] span;
   logic                               map_valid;
   logic [spwc_pkg::PULSE_W-1:0]       map_pulse;
   spwc_pkg::flags_type                map_flags;

   assign amount   = $signed(req_tdata[7:0]);
   assign duration = req_tdata[31:8];
   assign kind     = req_tuser;

   assign a_ready    = !a_valid_ff || map_ready;
   assign req_tready = a_ready;
   assign req_fire   = req_tvalid && a_ready;
   assign csr_ready  = 1'b1;

   // reverse swaps the ends of the range
   assign start = reverse_ff ? max_ff : min_ff;
   assign stop  = reverse_ff ? min_ff : max_ff;
   assign span  = $signed({1'b0, stop}) - $signed({1'b0, start});

   // decode the request and advance the countdown
   always_comb begin
      rem_in   = rem_ff;
      a_cmd_in = '{n: '0, div200: 1'b1, written: 1'b0, active: 1'b0};
      case (kind)
         spwc_pkg::KIND_ROTATE: begin
            a_cmd_in.n       = spwc_pkg::N_W'(amount) + spwc_pkg::SPEED_OFFSET;
            a_cmd_in.written = 1'b1;
            rem_in           = '0;
         end
         spwc_pkg::KIND_TIMED: begin
            a_cmd_in.n       = spwc_pkg::N_W'(amount) + spwc_pkg::SPEED_OFFSET;
            a_cmd_in.written = 1'b1;
            rem_in           = spwc_pkg::REM_W'(duration) + 1'b1;
         end
         spwc_pkg::KIND_POSITION: begin
            a_cmd_in.n       = spwc_pkg::N_W'(amount);
            a_cmd_in.div200  = 1'b0;
            a_cmd_in.written = 1'b1;
            rem_in           = '0;
         end
         default: begin
            // tick: count down, stop pulse on the last millisecond
            if (rem_ff != '0) begin
               rem_in = rem_ff - 1'b1;
               if (rem_ff == spwc_pkg::REM_W'(1)) begin
                  a_cmd_in.n       = spwc_pkg::SPEED_OFFSET;
                  a_cmd_in.written = 1'b1;
               end
            end
         end
      endcase
      a_cmd_in.active = (rem_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_ff <= 1'b0;
         min_ff     <= spwc_pkg::MIN_PULSE_RESET;
         max_ff     <= spwc_pkg::MAX_PULSE_RESET;
         rem_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               spwc_pkg::CSR_REVERSE: reverse_ff <= csr_data[0];
               spwc_pkg::CSR_MIN:     min_ff     <= csr_data;
               spwc_pkg::CSR_MAX:     max_ff     <= csr_data;
               default: ;   // drop writes beyond the register list
            endcase
         end
         if (req_fire) rem_ff <= rem_in;
         if (a_ready) a_valid_ff <= req_tvalid;
      end
   end

   // hold the accepted command for the mapping pipeline
   always_ff @(posedge clock) begin
      if (req_fire) a_cmd_ff <= a_cmd_in;
   end

   spwc_map u_map (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .in_ready  (map_ready),
      .in_cmd    (a_cmd_ff),
      .span      (span),
      .start     (start),
      .out_valid (map_valid),
      .out_ready (rsp_tready),
      .out_pulse (map_pulse),
      .out_flags (map_flags)
   );

   assign rsp_tvalid = map_valid;
   assign rsp_tdata  = {2'b00, map_flags.active, map_pulse};
   assign rsp_tuser  = map_flags.written;

`ifndef SYNTHESIS
   a_timed_loads: assert property (@(posedge clock) disable iff (reset)
      req_fire && kind == spwc_pkg::KIND_TIMED |=> rem_ff != '0)
      else $error("timed rotate did not start the countdown");

   a_untimed_cancels: assert property (@(posedge clock) disable iff (reset)
      req_fire && (kind == spwc_pkg::KIND_ROTATE || kind == spwc_pkg::KIND_POSITION)
      |=> rem_ff == '0)
      else $error("untimed command left a countdown running");

   a_idle_pulse_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[12:0] == '0)
      else $error("pulse width nonzero on a result without a new pulse");

   a_cmd_active_match: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> a_cmd_ff.active == (rem_ff != '0))
      else $error("active flag disagrees with countdown");
`endif

endmodule

[dv/tb_servo_pulse_width_commander_top.sv]
// Self-checking testbench for the servo pulse width commander top level.
`timescale 1ns / 1ps

module tb_servo_pulse_width_commander_top;

   // Mapping ranges: rotate speed and position percent
   localparam int SPEED_LO = -100;
   localparam int SPEED_HI = 100;
   localparam int POS_LO   = 0;
   localparam int POS_HI   = 100;
   localparam int WIDTH_CEIL = 8191;

   // Index past the register list; the block must ignore it
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // Drain allowance after the last result
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [spwc_pkg::PULSE_W-1:0] pulse_us;
      logic                         written;
      logic                         active;
   } servo_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [7:0] amount (signed), [31:8] duration_ms
   logic [1:0]  req_tuser;   // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [12:0] pulse_us, [13] timed_run_active, [15:14] zero
   logic        rsp_tuser;   // [0] pulse_written
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [11:0] csr_data;

   servo_pulse_width_commander_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Shadow copy of the block's registers and countdown
   logic                          shadow_reverse;
   logic [spwc_pkg::CFG_W-1:0]    shadow_min_us;
   logic [spwc_pkg::CFG_W-1:0]    shadow_max_us;
   logic [spwc_pkg::REM_W-1:0]    shadow_remaining;

   servo_result_type expected_pulses[$];

   // Knobs for the random idling on both sides
   bit req_gaps_on;
   bit rsp_stalls_on;

   int error_count;
   int requests_sent;
   int results_checked;
   int stop_pulses;
   int csr_writes;

   // Clock: 2 ns period
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   // Linear map onto the pulse span with truncating division, then clamp
   function automatic logic [spwc_pkg::PULSE_W-1:0] map_width(int pos, int lo, int hi);
      int start_us;
      int end_us;
      int w;
      start_us = shadow_reverse ? int'(shadow_max_us) : int'(shadow_min_us);
      end_us   = shadow_reverse ? int'(shadow_min_us) : int'(shadow_max_us);
      w = (pos - lo) * (end_us - start_us) / (hi - lo) + start_us;
      if (w < 0)
         w = 0;
      if (w > WIDTH_CEIL)
         w = WIDTH_CEIL;
      return w[spwc_pkg::PULSE_W-1:0];
   endfunction

   // Advance the shadow state by one accepted request and queue its result
   task automatic predict_pulse(logic [1:0] kind, logic signed [7:0] amount,
                                logic [23:0] dur);
      servo_result_type r;
      r = '0;
      case (kind)
         spwc_pkg::KIND_ROTATE: begin
            r.pulse_us = map_width(int'(amount), SPEED_LO, SPEED_HI);
            r.written = 1'b1;
            shadow_remaining = '0;
         end
         spwc_pkg::KIND_TIMED: begin
            r.pulse_us = map_width(int'(amount), SPEED_LO, SPEED_HI);
            r.written = 1'b1;
            shadow_remaining = {1'b0, dur} + 1'b1;
         end
         spwc_pkg::KIND_POSITION: begin
            r.pulse_us = map_width(int'(amount), POS_LO, POS_HI);
            r.written = 1'b1;
            shadow_remaining = '0;
         end
         default: begin
            // Tick: count down; the stop pulse goes out on expiry
            if (shadow_remaining != '0) begin
               shadow_remaining = shadow_remaining - 1'b1;
               if (shadow_remaining == '0) begin
                  r.pulse_us = map_width(0, SPEED_LO, SPEED_HI);
                  r.written = 1'b1;
                  stop_pulses++;
               end
            end
         end
      endcase
      r.active = (shadow_remaining != '0);
      expected_pulses.push_back(r);
   endtask

   // Send one request; an optional gap comes first, valid stays high after accept
   task automatic send_request(logic [1:0] kind, logic signed [7:0] amount,
                               logic [23:0] dur);
      int gap;
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {dur, amount};
      @(posedge clock);
      while (req_tready !== 1'b1)
         @(posedge clock);
      predict_pulse(kind, amount, dur);
      requests_sent++;
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_pulses.size() != 0)
         @(posedge clock);
   endtask

   // Register write; only called while the pipeline is empty
   task automatic write_csr(logic [1:0] index, logic [11:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      case (index)
         spwc_pkg::CSR_REVERSE: shadow_reverse = value[0];
         spwc_pkg::CSR_MIN:     shadow_min_us  = value;
         spwc_pkg::CSR_MAX:     shadow_max_us  = value;
         default:     ;
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_span(logic rev, logic [11:0] lo_us, logic [11:0] hi_us);
      settle_idle();
      write_csr(spwc_pkg::CSR_REVERSE, {11'($urandom_range(0, 2047)), rev});
      write_csr(spwc_pkg::CSR_MIN, lo_us);
      write_csr(spwc_pkg::CSR_MAX, hi_us);
   endtask

   // Pick a span end: favor the extremes and the reset values
   function automatic logic [11:0] pick_span_end();
      case ($urandom_range(0, 5))
         0:       return 12'd0;
         1:       return 12'd4095;
         2:       return 12'd4000;
         3:       return spwc_pkg::MIN_PULSE_RESET;
         4:       return spwc_pkg::MAX_PULSE_RESET;
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   // One random request: mostly well-formed commands and ticks, some noise
   task automatic send_random_request();
      int sel;
      logic [1:0] kind;
      logic signed [7:0] amount;
      logic [23:0] dur;
      sel = $urandom_range(0, 99);
      amount = 8'($urandom_range(0, 255));
      dur = 24'($urandom_range(0, 24'hFFFFFF));
      if (sel < 35) begin
         kind = spwc_pkg::KIND_TICK;
      end else if (sel < 50) begin
         kind = spwc_pkg::KIND_ROTATE;
         amount = 8'($urandom_range(0, 200) - 100);
      end else if (sel < 68) begin
         // Short runs so that most of them expire under the ticks
         kind = spwc_pkg::KIND_TIMED;
         amount = 8'($urandom_range(0, 200) - 100);
         if ($urandom_range(0, 9) != 0)
            dur = 24'($urandom_range(0, 15));
      end else if (sel < 85) begin
         kind = spwc_pkg::KIND_POSITION;
         amount = 8'($urandom_range(0, 100));
      end else begin
         kind = 2'($urandom_range(0, 3));
      end
      send_request(kind, amount, dur);
   endtask

   // Result check: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      servo_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (expected_pulses.size() == 0) begin
            $error("unexpected result: pulse_us %0d", rsp_tdata[12:0]);
            error_count++;
         end else begin
            want = expected_pulses.pop_front();
            results_checked++;
            if (rsp_tdata[12:0] !== want.pulse_us) begin
               $error("pulse_us: expected %0d, actual %0d", want.pulse_us,
                      rsp_tdata[12:0]);
               error_count++;
            end
            if (rsp_tuser !== want.written) begin
               $error("pulse_written: expected %0d, actual %0d", want.written,
                      rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[13] !== want.active) begin
               $error("timed_run_active: expected %0d, actual %0d", want.active,
                      rsp_tdata[13]);
               error_count++;
            end
         end
      end
   end

   // Result backpressure: random stall bursts while enabled
   initial begin
      int stall;
      forever begin
         if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 10);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // Directed: range ends, ticks while idle, timed runs, cancellation
   task automatic test_default_span();
      send_request(spwc_pkg::KIND_ROTATE, -8'sd100, 24'd0);
      send_request(spwc_pkg::KIND_ROTATE, 8'sd0, 24'hFFFFFF);
      send_request(spwc_pkg::KIND_ROTATE, 8'sd100, 24'd0);
      send_request(spwc_pkg::KIND_POSITION, 8'sd0, 24'd0);
      send_request(spwc_pkg::KIND_POSITION, 8'sd50, 24'd0);
      send_request(spwc_pkg::KIND_POSITION, 8'sd100, 24'd0);
      // Tick with no timed run pending
      send_request(spwc_pkg::KIND_TICK, 8'sd0, 24'd0);
      // Amount outside the nominal range; position -128 clamps at zero
      send_request(spwc_pkg::KIND_ROTATE, -8'sd128, 24'd0);
      send_request(spwc_pkg::KIND_ROTATE, 8'sd127, 24'd0);
      send_request(spwc_pkg::KIND_POSITION, -8'sd128, 24'd0);
      send_request(spwc_pkg::KIND_POSITION, 8'sd127, 24'd0);
      // Zero duration stops on the very next tick
      send_request(spwc_pkg::KIND_TIMED, 8'sd60, 24'd0);
      send_request(spwc_pkg::KIND_TICK, 8'sd0, 24'd0);
      send_request(spwc_pkg::KIND_TICK, 8'sd0, 24'd0);
      // Duration 2 stops on the third tick
      send_request(spwc_pkg::KIND_TIMED, -8'sd40, 24'd2);
      repeat (4) send_request(spwc_pkg::KIND_TICK, 8'sd0, 24'd0);
      // An untimed command cancels the run
      send_request(spwc_pkg::KIND_TIMED, 8'sd30, 24'd1);
      send_request(spwc_pkg::KIND_POSITION, 8'sd10, 24'd0);
      send_request(spwc_pkg::KIND_TICK, 8'sd0, 24'd0);
      send_request(spwc_pkg::KIND_TICK, 8'sd0, 24'd0);
      // Longest run stays active
      send_request(spwc_pkg::KIND_TIMED, 8'sd99, 24'hFFFFFF);
      send_request(spwc_pkg::KIND_TICK, 8'sd0, 24'hABCDEF);
      send_request(spwc_pkg::KIND_ROTATE, 8'sd1, 24'd0);
   endtask

   // Directed: extreme spans, reversal, both clamps, the ignored index
   task automatic test_span_extremes();
      write_span(1'b0, 12'd0, 12'd4095);
      send_request(spwc_pkg::KIND_POSITION, 8'sd127, 24'd0);
      send_request(spwc_pkg::KIND_ROTATE, -8'sd100, 24'd0);
      send_request(spwc_pkg::KIND_ROTATE, 8'sd127, 24'd0);
      write_span(1'b1, 12'd0, 12'd4095);
      // Reversed: large start, negative slope; -128 overshoots the ceiling
      send_request(spwc_pkg::KIND_POSITION, -8'sd128, 24'd0);
      send_request(spwc_pkg::KIND_POSITION, 8'sd127, 24'd0);
      send_request(spwc_pkg::KIND_TIMED, -8'sd128, 24'd0);
      send_request(spwc_pkg::KIND_TICK, 8'sd0, 24'd0);
      write_span(1'b0, 12'd4095, 12'd0);
      send_request(spwc_pkg::KIND_POSITION, -8'sd128, 24'd0);
      send_request(spwc_pkg::KIND_ROTATE, 8'sd100, 24'd0);
      write_span(1'b1, 12'd4000, 12'd4000);
      send_request(spwc_pkg::KIND_ROTATE, -8'sd77, 24'd0);
      settle_idle();
      // Index beyond the register list must leave the span untouched
      write_csr(CSR_UNUSED, 12'hFFF);
      write_csr(CSR_UNUSED, 12'h000);
      send_request(spwc_pkg::KIND_POSITION, 8'sd33, 24'd0);
      send_request(spwc_pkg::KIND_ROTATE, 8'sd0, 24'd0);
   endtask

   // Random: several spans, each followed by a burst of random requests
   task automatic test_random_spans(int phases, int per_phase);
      repeat (phases) begin
         write_span(1'($urandom_range(0, 1)), pick_span_end(), pick_span_end());
         repeat (per_phase) send_random_request();
      end
   endtask

   // Back-to-back traffic with no idling on either side
   task automatic test_full_rate(int count);
      settle_idle();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      write_span(1'b0, spwc_pkg::MIN_PULSE_RESET, spwc_pkg::MAX_PULSE_RESET);
      repeat (count) send_random_request();
   endtask

   initial begin
      error_count = 0;
      requests_sent = 0;
      results_checked = 0;
      stop_pulses = 0;
      csr_writes = 0;
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      shadow_reverse = 1'b0;
      shadow_min_us = spwc_pkg::MIN_PULSE_RESET;
      shadow_max_us = spwc_pkg::MAX_PULSE_RESET;
      shadow_remaining = '0;

      // Hold reset with every input at a known value
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= spwc_pkg::KIND_ROTATE;
      csr_valid  <= 1'b0;
      csr_index  <= spwc_pkg::CSR_REVERSE;
      csr_data   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_default_span();
      test_span_extremes();
      test_random_spans(5, 300);
      test_full_rate(350);

      // Let the pipeline empty, then watch for stray results
      settle_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_pulses.size() != 0)
         error_count++;

      $display("Covered %0d requests, %0d results checked, %0d stop pulses,",
               requests_sent, results_checked, stop_pulses);
      $display("%0d register writes across default, extreme and random spans.",
               csr_writes);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[files.f]
rtl/spwc_pkg.sv
rtl/spwc_map.sv
rtl/servo_pulse_width_commander_top.sv
dv/tb_servo_pulse_width_commander_top.sv
